// ----- hdl/mbs_pkg.sv -----
package mbs_pkg;

  // Histogram geometry and field widths
  localparam int CountWidth = 32;
  localparam int NumBins    = 256;
  localparam int BinAw      = 8;
  localparam int VoxW       = 8;

  typedef logic [CountWidth-1:0] cnt_t;
  typedef logic [VoxW-1:0]       vox_t;

  // Operation codes carried on the input tuser
  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpCount = 2'd1,
    OpSub   = 2'd2,
    OpNop   = 2'd3
  } op_e;

  // Histogram update command from the update logic to the bin store
  typedef struct packed {
    logic             en;
    logic             clr;
    logic [BinAw-1:0] addr;
    cnt_t             count;
  } hist_wr_t;

endpackage

// ----- hdl/mode_background_subtract.sv -----
// Mode background subtraction for 8-bit voxel streams.
// Input channel s_axis: tuser carries the opcode (clear, count, subtract, no-op),
// tdata carries the voxel. Output channel m_axis: one beat per input beat,
// tdata holds the clamped difference (low byte) and the current mode (high
// byte). Run a clear, stream the volume with count, then stream it again
// with subtract to remove the most common value.
// An accepted beat passes the working stage and then the result register.
// Throughput: one beat per cycle while m_axis is ready. The bin memory is read
// at acceptance and written as the working stage fires; a read-after-write
// on the same bin is bypassed, so equal back-to-back voxels count correctly.
// Reset clears valid state, the histogram (through per-bin valid flags) and
// the mode; no clearing pass is needed, the block is ready right away.
// When m_axis stalls, the result beat is held and one more input beat can
// be taken into the working stage before s_axis_tready_o drops.
module mode_background_subtract import mbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] voxel
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [7:0] out_voxel, [15:8] mode_value
);

  logic     accept;
  logic     s1_fire;
  logic     s1_vld_q;
  op_e      s1_op_q;
  vox_t     s1_voxel_q;
  logic     out_vld_q;
  vox_t     out_voxel_q;
  vox_t     out_mode_q;
  cnt_t     best_cnt_q;
  vox_t     best_val_q;
  cnt_t     best_cnt_d;
  vox_t     best_val_d;
  vox_t     out_voxel_d;
  vox_t     out_mode_d;
  cnt_t     bin_count;
  hist_wr_t hist_wr;

  // Handshake: the working stage drains into the result register
  assign s1_fire         = s1_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_vld_q || s1_fire;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  mbs_hist u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (s_axis_tdata_i[BinAw-1:0]),
    .wr_i       (hist_wr),
    .rd_count_o (bin_count)
  );

  mbs_update u_update (
    .fire_i      (s1_fire),
    .op_i        (s1_op_q),
    .voxel_i     (s1_voxel_q),
    .bin_count_i (bin_count),
    .best_cnt_i  (best_cnt_q),
    .best_val_i  (best_val_q),
    .wr_o        (hist_wr),
    .best_cnt_o  (best_cnt_d),
    .best_val_o  (best_val_d),
    .out_voxel_o (out_voxel_d),
    .out_mode_o  (out_mode_d)
  );

  // Working stage: capture the beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_e'(s_axis_tuser_i);
      s1_voxel_q <= s_axis_tdata_i;
    end
  end

  // Running mode: advance when the stage fires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_cnt_q <= '0;
      best_val_q <= '0;
    end else if (s1_fire) begin
      best_cnt_q <= best_cnt_d;
      best_val_q <= best_val_d;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_voxel_q <= out_voxel_d;
      out_mode_q  <= out_mode_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_mode_q, out_voxel_q};

`ifndef SYNTHESIS
  // A clear always reports an empty-histogram mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_op_q == OpClear)) |=> (out_mode_q == '0))
    else $error("mode not zero after clear");

  // Only subtract produces a nonzero voxel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_op_q != OpSub)) |=> (out_voxel_q == '0))
    else $error("nonzero voxel from non-subtract beat");

  // Subtraction never exceeds the input voxel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_op_q == OpSub)) |=> (out_voxel_q <= $past(s1_voxel_q)))
    else $error("subtract result above input");

  // After counting a voxel the best count is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_op_q == OpCount)) |=> (best_cnt_q != '0))
    else $error("best count zero after count");
`endif

endmodule

// ----- hdl/mbs_hist.sv -----
module mbs_hist import mbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [BinAw-1:0] rd_addr_i,
  input  hist_wr_t         wr_i,
  output cnt_t             rd_count_o
);

  cnt_t               mem_q [NumBins];
  cnt_t               rd_data_q;
  logic [NumBins-1:0] valid_q;
  logic               rd_vld_q;
  logic               fwd_q;
  cnt_t               fwd_cnt_q;

  // Bin memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.count;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Per-bin valid flags: clear drops all at once, a write marks its bin
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.clr) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // Capture valid flag and bypass the write landing on the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (rd_en_i) begin
      rd_vld_q <= valid_q[rd_addr_i];
      fwd_q    <= wr_i.clr || (wr_i.en && (wr_i.addr == rd_addr_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_cnt_q <= wr_i.clr ? '0 : wr_i.count;
    end
  end

  assign rd_count_o = fwd_q    ? fwd_cnt_q :
                      rd_vld_q ? rd_data_q : '0;

endmodule

// ----- hdl/mbs_update.sv -----
module mbs_update import mbs_pkg::*; (
  input  logic     fire_i,
  input  op_e      op_i,
  input  vox_t     voxel_i,
  input  cnt_t     bin_count_i,
  input  cnt_t     best_cnt_i,
  input  vox_t     best_val_i,
  output hist_wr_t wr_o,
  output cnt_t     best_cnt_o,
  output vox_t     best_val_o,
  output vox_t     out_voxel_o,
  output vox_t     out_mode_o
);

  cnt_t inc_cnt;
  logic take;

  // Saturating increment and running-mode compare
  assign inc_cnt = (bin_count_i == '1) ? bin_count_i : bin_count_i + 1'b1;
  assign take    = (inc_cnt > best_cnt_i) ||
                   ((inc_cnt == best_cnt_i) && (voxel_i < best_val_i));

  always_comb begin
    wr_o.en     = 1'b0;
    wr_o.clr    = 1'b0;
    wr_o.addr   = voxel_i;
    wr_o.count  = inc_cnt;
    best_cnt_o  = best_cnt_i;
    best_val_o  = best_val_i;
    out_voxel_o = '0;
    unique case (op_i)
      OpClear: begin
        wr_o.clr   = fire_i;
        best_cnt_o = '0;
        best_val_o = '0;
      end
      OpCount: begin
        wr_o.en = fire_i;
        if (take) begin
          best_cnt_o = inc_cnt;
          best_val_o = voxel_i;
        end
      end
      OpSub: begin
        out_voxel_o = (voxel_i > best_val_i) ? voxel_i - best_val_i : '0;
      end
      OpNop: begin
      end
      default: begin
      end
    endcase
    out_mode_o = best_val_o;
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mbs_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int MaxShown   = 10;

  // Result beat as it sits on m_axis tdata: difference low, mode high
  typedef struct packed {
    vox_t mode;
    vox_t diff;
  } bg_result_t;

  logic       clk_i    = 1'b0;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;   // [7:0] voxel
  logic [1:0] s_tuser  = '0;   // [1:0] opcode
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [15:0] m_tdata;        // [7:0] out_voxel, [15:8] mode_value

  // Predicted histogram and running mode
  cnt_t hist_bins [NumBins];
  cnt_t peak_count;
  vox_t peak_value;
  bg_result_t diff_mode_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  mode_background_subtract dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Empty the predicted histogram and the mode
  task automatic clear_hist_model();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    peak_count = '0;
    peak_value = '0;
  endtask

  // Apply one beat to the predicted state and queue the expected result
  task automatic predict_bg_step(input op_e op, input vox_t vox);
    bg_result_t r;
    cnt_t c;
    r.diff = '0;
    case (op)
      OpClear: clear_hist_model();
      OpCount: begin
        c = hist_bins[vox];
        if (c != '1) c = c + 1'b1;
        hist_bins[vox] = c;
        if (c > peak_count || (c == peak_count && vox < peak_value)) begin
          peak_count = c;
          peak_value = vox;
        end
      end
      OpSub: r.diff = (vox > peak_value) ? vox - peak_value : '0;
      default: ;
    endcase
    r.mode = peak_value;
    diff_mode_q.push_back(r);
  endtask

  // Offer one beat, idling first at random; returns at the accepting edge
  task automatic send_beat(input op_e op, input vox_t vox);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= vox;
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    predict_bg_step(op, vox);
    @(posedge clk_i);
  endtask

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= MaxShown) $display("tb: %0t: %s", $time, msg);
  endfunction

  // Compare one result beat with the oldest expectation
  task automatic check_beat(input bg_result_t got);
    bg_result_t want;
    if (diff_mode_q.size() == 0) begin
      note_error($sformatf("result beat %h with nothing pending", got));
    end else begin
      want = diff_mode_q.pop_front();
      if (got.diff !== want.diff)
        note_error($sformatf("out_voxel expected %0d got %0d", want.diff, got.diff));
      if (got.mode !== want.mode)
        note_error($sformatf("mode_value expected %0d got %0d", want.mode, got.mode));
    end
  endtask

  // Drive output ready: random stalls, or a long hold when requested
  initial begin : rx_ready
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Sample result beats between edges, where all signals are settled
  always @(negedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) check_beat(bg_result_t'(m_tdata));
  end

  // Abort when no beat moves on either side for too long
  always @(negedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Empty histogram, ties, opcode no-op, voxel extremes
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(OpSub, 8'd0);      // empty histogram, mode is zero
    send_beat(OpSub, 8'hFF);
    send_beat(OpCount, 8'd7);
    send_beat(OpCount, 8'd3);    // tie at one, lower value takes the mode
    send_beat(OpCount, 8'd7);    // 7 leads
    send_beat(OpCount, 8'd3);    // tie at two, back to 3
    send_beat(OpSub, 8'd2);      // clamp at zero
    send_beat(OpSub, 8'd3);
    send_beat(OpSub, 8'd200);
    send_beat(OpNop, 8'hFF);     // unused opcode leaves state alone
    send_beat(OpCount, 8'hFF);
    send_beat(OpCount, 8'd0);
    send_beat(OpCount, 8'd0);
    send_beat(OpCount, 8'd0);    // 0 reaches three; it already took the mode on the tie at two
    send_beat(OpSub, 8'hFF);
    send_beat(OpSub, 8'd0);
    send_beat(OpClear, 8'hAA);   // voxel ignored on clear
    send_beat(OpNop, 8'h55);
    send_beat(OpSub, 8'h80);
    send_beat(OpCount, 8'hFF);   // lone top bin becomes the mode
    send_beat(OpSub, 8'hFE);
    send_beat(OpSub, 8'hFF);
    send_beat(OpClear, 8'd0);
  endtask

  // Mostly clear first, count a small volume, subtract it again; noise beats mixed in
  task automatic test_random_volumes(input int n_beats, input int idle_pct,
                                     input int stall_pct);
    vox_t volume [$];
    vox_t bg;
    int sent;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(9) == 0) begin
        send_beat(op_e'($urandom_range(3)), vox_t'($urandom_range(255)));
        sent++;
      end else begin
        len = $urandom_range(1, 24);
        bg  = vox_t'($urandom_range(255));
        volume.delete();
        for (int i = 0; i < len; i++) begin
          // pairs of neighbor values around the background make ties common
          if ($urandom_range(99) < 60) volume.push_back(bg ^ vox_t'($urandom_range(1)));
          else volume.push_back(vox_t'($urandom_range(255)));
        end
        // sometimes keep the old histogram to let counts pile up
        if ($urandom_range(3) != 0) send_beat(OpClear, vox_t'($urandom_range(255)));
        foreach (volume[i]) send_beat(OpCount, volume[i]);
        foreach (volume[i]) send_beat(OpSub, volume[i]);
        sent += 2 * len + 1;
      end
    end
  endtask

  // Hold off the output for a long stretch while beats keep coming
  task automatic test_output_hold();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    s_tvalid <= 1'b0;
    @(negedge clk_i);
    hold_req = 200;
    @(posedge clk_i);
    send_beat(OpClear, 8'd0);
    for (int i = 0; i < 40; i++) begin
      send_beat((i < 20) ? OpCount : OpSub, vox_t'($urandom_range(4)));
    end
  endtask

  initial begin
    clear_hist_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_volumes(180, 0, 0);
    test_random_volumes(180, 69, 0);
    test_random_volumes(180, 0, 69);
    test_output_hold();
    test_random_volumes(180, 35, 35);

    // Drain and let the pipeline settle
    s_tvalid <= 1'b0;
    while (diff_mode_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && diff_mode_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
